// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond in the same cycle implies prop
`define QTE_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("assertion failed");

// cond implies prop in the next cycle
`define QTE_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== hdl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Constants, types and the arctangent table of the quaternion to Euler block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_LEN     = 24;
  localparam int unsigned CSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  localparam int unsigned SQ_STEPS = 31;  // one result bit per stage
  localparam int unsigned LAT      = 3 + SQ_STEPS + CSTEPS + 2;

  localparam int unsigned TERM_W = 34;  // atan2 operand terms
  localparam int unsigned XW     = 38;  // CORDIC x/y with gain headroom
  localparam int unsigned ZW     = 35;  // CORDIC angle, Q.30 radians
  localparam int unsigned RAD_W  = 62;

  localparam logic signed [ZW-1:0]  PI_Q30       = 35'sd3373259426;
  localparam logic signed [31:0]    ASIN_MAX_Q30 = 32'sd1073731087;
  localparam logic signed [31:0]    ONE_Q30      = 32'sd1073741824;
  localparam logic signed [15:0]    LIM_PI       = 16'sd25736;
  localparam logic signed [15:0]    LIM_HALF_PI  = 16'sd12868;

  typedef struct packed {
    logic signed [TERM_W-1:0] yaw_y;
    logic signed [TERM_W-1:0] yaw_x;
    logic signed [TERM_W-1:0] roll_y;
    logic signed [TERM_W-1:0] roll_x;
    logic signed [31:0]       sin_p;
  } term_t;

  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qte_isqrt.sv =====
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one result bit resolved per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_isqrt import qte_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [60:0]      rad_i,
  output logic      [30:0]      root_o
);

  logic [RAD_W-1:0] v_q [SQ_STEPS];
  logic [RAD_W-1:0] r_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    localparam logic [RAD_W-1:0] SQ_BIT = RAD_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [RAD_W-1:0] v_src, r_src, trial;

    if (k == 0) begin : g_first
      assign v_src = RAD_W'(rad_i);
      assign r_src = '0;
    end else begin : g_next
      assign v_src = v_q[k-1];
      assign r_src = r_q[k-1];
    end

    assign trial = r_src + SQ_BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_src >= trial) begin
          v_q[k] <= v_src - trial;
          r_q[k] <= (r_src >> 1) + SQ_BIT;
        end else begin
          v_q[k] <= v_src;
          r_q[k] <= r_src >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQ_STEPS-1][30:0];

endmodule

`default_nettype wire

// ===== hdl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2 with rounding to Q3.13 and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic import qte_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [TERM_W-1:0] y_i,
  input  wire logic signed [TERM_W-1:0] x_i,
  input  wire logic signed [15:0]       limit_i,
  output logic signed      [15:0]       angle_o
);

  localparam int unsigned RW = ZW - 17;

  logic signed [XW-1:0] x_q [CSTEPS+1];
  logic signed [XW-1:0] y_q [CSTEPS+1];
  logic signed [ZW-1:0] z_q [CSTEPS+1];
  logic                 zero_q [CSTEPS+1];
  logic signed [15:0]   angle_q;

  // left half plane: rotate by pi first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -XW'(x_i);
        y_q[0] <= -XW'(y_i);
        z_q[0] <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_q[0] <= XW'(x_i);
        y_q[0] <= XW'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CSTEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_q30(i));
    logic signed [XW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - ATAN_I;
        end
      end
    end
  end

  logic signed [ZW-1:0] z_rnd;
  logic signed [RW-1:0] r, lim_w;
  logic signed [15:0]   angle_d;

  assign z_rnd = z_q[CSTEPS] + ZW'(65536);
  assign r     = $signed(z_rnd[ZW-1:17]);
  assign lim_w = RW'(limit_i);

  always_comb begin
    if (zero_q[CSTEPS]) begin
      angle_d = '0;
    end else if (r > lim_w) begin
      angle_d = limit_i;
    end else if (r < -lim_w) begin
      angle_d = -limit_i;
    end else begin
      angle_d = r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== hdl/quaternion_to_zyx_euler_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_zyx_euler_top
// Converts Q1.15 attitude quaternions to Z-Y-X Euler angles in Q3.13 radians.
// ----------------------------------------------------------------------------
// channel   dir   tdata fields (low bit up)
// s_axis    in    quat_w[15:0] quat_x[31:16] quat_y[47:32] quat_z[63:48]
// m_axis    out   yaw_angle[15:0] pitch_angle[30:16] roll_angle[46:31], pad
//
// One request per cycle while the output is not stalled; the pipeline holds
// products, terms, the square, 31 square-root stages and the CORDIC (prep, 16 steps, rounding).
// The square-root pipeline for the pitch cosine sets the depth.
// Reset clears only the valid bits. When the output holds a result that is
// not taken, the whole pipeline halts and s_axis_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_to_zyx_euler_top import qte_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // yaw_angle, pitch_angle, roll_angle, 0
);

  `include "assert_macros.svh"

  logic en;
  logic [LAT-1:0] vld_q;

  assign m_axis_tvalid = vld_q[LAT-1];
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: products
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, yz_q, wx_q, wy_q, xz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= qw * qw;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      zz_q <= qz * qz;
      xy_q <= qx * qy;
      wz_q <= qw * qz;
      yz_q <= qy * qz;
      wx_q <= qw * qx;
      wy_q <= qw * qy;
      xz_q <= qx * qz;
    end
  end

  // stage 2: atan2 terms and the clamped sine of pitch
  term_t s2_d, s2_q;
  logic signed [TERM_W-1:0] s_raw;

  always_comb begin
    s2_d.yaw_y  = (TERM_W'(xy_q) + TERM_W'(wz_q)) <<< 1;
    s2_d.yaw_x  = TERM_W'(ww_q) + TERM_W'(xx_q) - TERM_W'(yy_q) - TERM_W'(zz_q);
    s2_d.roll_y = (TERM_W'(yz_q) + TERM_W'(wx_q)) <<< 1;
    s2_d.roll_x = TERM_W'(ww_q) - TERM_W'(xx_q) - TERM_W'(yy_q) + TERM_W'(zz_q);
    s_raw       = (TERM_W'(wy_q) - TERM_W'(xz_q)) <<< 1;
    if (s_raw > TERM_W'(ASIN_MAX_Q30)) begin
      s2_d.sin_p = ASIN_MAX_Q30;
    end else if (s_raw < -TERM_W'(ONE_Q30)) begin
      s2_d.sin_p = -ONE_Q30;
    end else begin
      s2_d.sin_p = s_raw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: radicand 1 - s^2 in Q.60
  logic signed [63:0] ss;
  logic [60:0] rad_q;
  term_t s3_q;

  assign ss = s2_q.sin_p * s2_q.sin_p;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= (61'd1 << 60) - ss[60:0];
      s3_q  <= s2_q;
    end
  end

  logic [30:0] cos_p;

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (cos_p)
  );

  // terms wait alongside the square root
  term_t dly_q [SQ_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= s3_q;
      for (int j = 1; j < SQ_STEPS; j++) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  logic signed [15:0] yaw, pitch, roll;

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (dly_q[SQ_STEPS-1].yaw_y),
    .x_i     (dly_q[SQ_STEPS-1].yaw_x),
    .limit_i (LIM_PI),
    .angle_o (yaw)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (TERM_W'(dly_q[SQ_STEPS-1].sin_p)),
    .x_i     ($signed(TERM_W'(cos_p))),
    .limit_i (LIM_HALF_PI),
    .angle_o (pitch)
  );

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (dly_q[SQ_STEPS-1].roll_y),
    .x_i     (dly_q[SQ_STEPS-1].roll_x),
    .limit_i (LIM_PI),
    .angle_o (roll)
  );

  assign m_axis_tdata = {1'b0, roll, pitch[14:0], yaw};

  `QTE_ASSERT_NOW(a_yaw_range, m_axis_tvalid, (yaw <= LIM_PI) && (yaw >= -LIM_PI))
  `QTE_ASSERT_NOW(a_roll_range, m_axis_tvalid, (roll <= LIM_PI) && (roll >= -LIM_PI))
  `QTE_ASSERT_NOW(a_pitch_range, m_axis_tvalid,
                  (pitch <= LIM_HALF_PI) && (pitch >= -LIM_HALF_PI))
  `QTE_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0])

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams quaternions into quaternion_to_zyx_euler_top and checks every Euler
// angle triple against an in-bench fixed-point CORDIC prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import qte_pkg::*;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  euler_t angles_pending[$];
  int     send_idle_pct;
  int     recv_stall_pct;
  int     mismatches;
  int     requests_sent;
  int     results_seen;

  quaternion_to_zyx_euler_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #5000000;
    $display("quaternion_to_zyx_euler_top verification failed");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sqrt_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x, longint limit);
    longint ang;
    longint xs;
    longint ys;
    longint r;
    if (x == 0 && y == 0) return 0;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CSTEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + longint'(atan_q30(i));
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - longint'(atan_q30(i));
      end
    end
    r = floor_shift(ang + 65536, 17);
    if (r > limit) r = limit;
    if (r < -limit) r = -limit;
    return r;
  endfunction

  function automatic euler_t predict_euler(logic [63:0] q);
    longint w, x, y, z, s, c;
    longint unsigned rad;
    euler_t e;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    e.yaw = 16'(vector_angle(2 * (x * y + w * z), w*w + x*x - y*y - z*z, 25736));
    e.roll = 16'(vector_angle(2 * (y * z + w * x), w*w - x*x - y*y + z*z, 25736));
    s = 2 * (w * y - x * z);
    if (s > longint'(ASIN_MAX_Q30)) s = longint'(ASIN_MAX_Q30);
    if (s < -longint'(ONE_Q30)) s = -longint'(ONE_Q30);
    rad = (64'd1 << 60) - 64'(s * s);
    c = sqrt_floor(rad);
    e.pitch = 15'(vector_angle(s, c, 12868));
    return e;
  endfunction

  // tvalid stays high between back-to-back requests; it drops on idle and while results drain
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    logic [63:0] q;
    q = {z, y, x, w};
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= q;
    angles_pending.push_back(predict_euler(q));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (angles_pending.size() != 0) @(posedge clk_i);
  endtask

  // extremes, zero vector, left half plane with y = 0, clamps at both ends
  task automatic test_directed();
    logic [15:0] corner[5];
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    send_quat(16'h7fff, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(0, 16'h7fff, 0, 0);
    send_quat(0, 0, 0, 16'h7fff);
    send_quat(16'h5a82, 0, 16'h5a82, 0);
    send_quat(16'h5a82, 0, 16'ha57e, 0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    for (int i = 0; i < 5; i++)
      send_quat(corner[i], corner[(i+1)%5], corner[(i+2)%5], corner[(i+3)%5]);
    send_quat(16'h0001, 0, 0, 0);
    send_quat(0, 16'h0001, 16'h0001, 0);
    drain_results();
  endtask

  // mostly components within +/-16383, some with tiny or raw random components
  task automatic test_random(int n);
    logic [15:0] c[4];
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(9);
      for (int k = 0; k < 4; k++) begin
        if (kind < 6) c[k] = 16'($signed($urandom_range(32766)) - 16383);
        else if (kind < 8) c[k] = 16'($urandom);
        else c[k] = 16'($signed($urandom_range(16)) - 8);
      end
      if (kind == 0) c[$urandom_range(3)] = 16'h7fff;
      send_quat(c[0], c[1], c[2], c[3]);
      if (i == n / 2) drain_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 15;
    recv_stall_pct = 73;
    test_directed();
    test_random(160);
    send_idle_pct = 73;
    recv_stall_pct = 15;
    test_random(160);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(180);
    drain_results();
    repeat (LAT + 10) @(posedge clk_i);
    $display("Sent %0d quaternions (corners, clamps, zero vectors, random), %0d results",
             requests_sent, results_seen);
    if (mismatches == 0 && angles_pending.size() == 0) begin
      $display("quaternion_to_zyx_euler_top verification clean");
    end else begin
      $display("quaternion_to_zyx_euler_top verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    euler_t got;
    euler_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[46:0];
      results_seen++;
      if (angles_pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
      end else begin
        want = angles_pending.pop_front();
        if (got.yaw !== want.yaw) begin
          $display("%0t: yaw expected %0d got %0d", $time, want.yaw, got.yaw);
          mismatches++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch expected %0d got %0d", $time, want.pitch, got.pitch);
          mismatches++;
        end
        if (got.roll !== want.roll) begin
          $display("%0t: roll expected %0d got %0d", $time, want.roll, got.roll);
          mismatches++;
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/qte_pkg.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_zyx_euler_top.sv
test/testbench.sv
